FILE: rtl/tlpq_pkg.sv
// Shared types and codes for the three-level priority queue.
`timescale 1ns / 1ps
package tlpq_pkg;

  // Field widths
  localparam int DATA_W  = 8;
  localparam int PRIO_W  = 2;
  localparam int CMD_W   = 2;
  localparam int ST_W    = 2;
  localparam int COUNT_W = 5;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CREATE  = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK          = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY       = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL        = 2'd2;
  localparam logic [ST_W-1:0] ST_NOT_CREATED = 2'd3;

  // Highest priority, used when a zero priority comes in
  localparam logic [PRIO_W-1:0] PRIO_TOP = 2'd1;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch;  // capture the input beat
    logic exec;   // apply the command and load the result register
  } ctl_t;

endpackage

FILE: rtl/three_level_priority_queue.sv
// Top level of the three-level priority queue.
// Bounded priority queue of CAPACITY byte items with priorities 1 (first out) to 3;
// equal priorities leave oldest first. Every command beat (insert, dequeue, create)
// returns exactly one result beat with the dequeued item (zero otherwise), a status
// and the low five bits of the count held afterwards. A beat is registered first; once
// the result register is free, the whole cell array then shifts in parallel to
// insert or remove. The next command beat is taken the cycle after the result is
// registered, while that result still waits; the block stalls only when a new result
// is ready and the previous one has not been taken. No clearing pass follows reset.
`timescale 1ns / 1ps
module three_level_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // item_data[7:0], item_priority[9:8], zeros
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // out_data[7:0], out_priority[9:8], status[11:10],
                                 // entry_count[16:12], zeros
);
  import tlpq_pkg::*;

  ctl_t               ctl;
  logic [DATA_W-1:0]  out_data;
  logic [PRIO_W-1:0]  out_priority;
  logic [ST_W-1:0]    status;
  logic [COUNT_W-1:0] entry_count;

  tlpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .ctl      (ctl)
  );

  tlpq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .cmd           (s_tuser),
    .item_data     (s_tdata[7:0]),
    .item_priority (s_tdata[9:8]),
    .out_data      (out_data),
    .out_priority  (out_priority),
    .status        (status),
    .entry_count   (entry_count)
  );

  // Pack the result beat
  assign m_tdata = {7'b0, entry_count, status, out_priority, out_data};

endmodule

FILE: rtl/tlpq_ctrl.sv
// Handshake controller for the three-level priority queue.
`timescale 1ns / 1ps
module tlpq_ctrl (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  output logic         m_tvalid,
  input  logic         m_tready,
  output tlpq_pkg::ctl_t ctl
);
  import tlpq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;
  logic   out_free;

  // Result register can take a new beat when empty or draining now
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  // Drive datapath commands
  always_comb begin
    ctl.latch = s_tvalid && s_tready;
    ctl.exec  = (state == S_EXEC) && out_free;
  end

  // Hold state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (m_tready) m_tvalid <= 1'b0;
          if (s_tvalid) state <= S_EXEC;
        end
        S_EXEC: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/tlpq_datapath.sv
// Sorted cell array, input register and result register of the priority queue.
`timescale 1ns / 1ps
module tlpq_datapath #(
  parameter int CAPACITY = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tlpq_pkg::ctl_t                ctl,
  input  logic [tlpq_pkg::CMD_W-1:0]    cmd,
  input  logic [tlpq_pkg::DATA_W-1:0]   item_data,
  input  logic [tlpq_pkg::PRIO_W-1:0]   item_priority,
  output logic [tlpq_pkg::DATA_W-1:0]   out_data,
  output logic [tlpq_pkg::PRIO_W-1:0]   out_priority,
  output logic [tlpq_pkg::ST_W-1:0]     status,
  output logic [tlpq_pkg::COUNT_W-1:0]  entry_count
);
  import tlpq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Cell contents; only cells below the count are meaningful
  logic [DATA_W-1:0] slot_data      [CAPACITY];
  logic [PRIO_W-1:0] slot_priority  [CAPACITY];
  logic [DATA_W-1:0] slot_data_next [CAPACITY];
  logic [PRIO_W-1:0] slot_prio_next [CAPACITY];

  logic [CNT_W-1:0]  held_count;
  logic [CNT_W-1:0]  held_count_next;
  logic              queue_created;
  logic              queue_created_next;

  // Captured input beat
  logic [CMD_W-1:0]  in_cmd;
  logic [DATA_W-1:0] in_data;
  logic [PRIO_W-1:0] in_prio;

  logic [DATA_W-1:0] res_data;
  logic [PRIO_W-1:0] res_prio;
  logic [ST_W-1:0]   res_status;

  logic [CAPACITY-1:0] keep;      // cell is held and sorts ahead of the new item
  logic [CAPACITY-1:0] keep_prev; // same flag of the cell in front
  logic                full;

  // Capture the beat, folding a zero priority into the top level
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      in_cmd  <= cmd;
      in_data <= item_data;
      in_prio <= (item_priority == '0) ? PRIO_TOP : item_priority;
    end
  end

  // Flag cells that stay in place on insert
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      keep[i] = (CNT_W'(i) < held_count) && (slot_priority[i] <= in_prio);
    end
    keep_prev[0] = 1'b1;
    for (int i = 1; i < CAPACITY; i++) begin
      keep_prev[i] = keep[i-1];
    end
  end

  assign full = (held_count == CNT_W'(CAPACITY));

  // Work out next cell contents and the result
  always_comb begin
    slot_data_next     = slot_data;
    slot_prio_next     = slot_priority;
    held_count_next    = held_count;
    queue_created_next = queue_created;
    res_data           = '0;
    res_prio           = '0;
    res_status         = ST_OK;
    case (in_cmd)
      CMD_CREATE: begin
        queue_created_next = 1'b1;
        held_count_next    = CNT_W'(1);
        slot_data_next[0]  = in_data;
        slot_prio_next[0]  = in_prio;
      end
      CMD_INSERT: begin
        if (!queue_created) begin
          res_status = ST_NOT_CREATED;
        end else if (full) begin
          res_status = ST_FULL;
        end else begin
          // Each cell keeps, takes the new item, or takes its front neighbor
          for (int i = 0; i < CAPACITY; i++) begin
            if (!keep[i]) begin
              if (keep_prev[i]) begin
                slot_data_next[i] = in_data;
                slot_prio_next[i] = in_prio;
              end else begin
                slot_data_next[i] = slot_data[(i == 0) ? 0 : i - 1];
                slot_prio_next[i] = slot_priority[(i == 0) ? 0 : i - 1];
              end
            end
          end
          held_count_next = held_count + CNT_W'(1);
        end
      end
      CMD_DEQUEUE: begin
        if (!queue_created) begin
          res_status = ST_NOT_CREATED;
        end else if (held_count == '0) begin
          res_status = ST_EMPTY;
        end else begin
          res_data = slot_data[0];
          res_prio = slot_priority[0];
          // Advance every cell one place toward the front
          for (int i = 0; i < CAPACITY - 1; i++) begin
            slot_data_next[i] = slot_data[i+1];
            slot_prio_next[i] = slot_priority[i+1];
          end
          held_count_next = held_count - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Update cells and the result register
  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      slot_data     <= slot_data_next;
      slot_priority <= slot_prio_next;
      out_data      <= res_data;
      out_priority  <= res_prio;
      status        <= res_status;
      entry_count   <= COUNT_W'(held_count_next);
    end
  end

  // Hold count and created flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count    <= '0;
      queue_created <= 1'b0;
    end else if (ctl.exec) begin
      held_count    <= held_count_next;
      queue_created <= queue_created_next;
    end
  end

endmodule

FILE: rtl/tlpq_checker.sv
// Port-level checks for the three-level priority queue, bound to the top level.
`timescale 1ns / 1ps
module tlpq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);
  import tlpq_pkg::*;

  // Stalled result beat stays up
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

  // Refused commands carry no item
  a_no_item_on_error: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[11:10] != ST_OK) |-> (m_tdata[9:0] == 10'd0))
    else $error("item reported with a non-ok status");

  // Uncreated queue holds nothing
  a_not_created_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[11:10] == ST_NOT_CREATED) |-> (m_tdata[16:12] == 5'd0))
    else $error("count nonzero on an uncreated queue");

  // One command in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second command taken before the first finished");

endmodule

bind three_level_priority_queue tlpq_checker u_tlpq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: test/tb_top.sv
// Testbench for the three-level priority queue: stream driver, result checker, predictor.
`timescale 1ns / 1ps
module tb_top;
  import tlpq_pkg::*;

  // Command code the block treats as a no-op
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
  localparam int DEPTH = 16;
  localparam int RANDOM_CMDS = 650;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic             wait_idle;  // hold this beat until every result is back
    logic [CMD_W-1:0] cmd;
    logic [DATA_W-1:0] data;
    logic [PRIO_W-1:0] prio;
  } cmd_item_t;

  typedef struct packed {
    logic [DATA_W-1:0]  data;
    logic [PRIO_W-1:0]  prio;
    logic [ST_W-1:0]    status;
    logic [COUNT_W-1:0] count;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // item_data[7:0], item_priority[9:8], zeros
  logic [1:0]  s_tuser = '0;   // cmd[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // out_data[7:0], out_priority[9:8], status[11:10],
                               // entry_count[16:12], zeros

  cmd_item_t cmd_backlog[$];
  result_t   pending_results[$];

  // Predicted queue contents, front at index 0
  logic [DATA_W-1:0] pq_data[DEPTH];
  logic [PRIO_W-1:0] pq_prio[DEPTH];
  int                pq_count = 0;
  logic              pq_made = 1'b0;

  int   fail_count = 0;
  int   cycles = 0;
  logic in_taken = 1'b0;
  int   burst_left = 0;
  int   gap_left = 0;
  int   sink_mode = 0;
  int   sink_left = 0;

  three_level_priority_queue dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one command to the predicted queue and return the result it should give
  function automatic result_t serve_command(cmd_item_t it);
    result_t r;
    logic [PRIO_W-1:0] p;
    int pos;
    r = '0;
    p = (it.prio == '0) ? PRIO_TOP : it.prio;
    r.status = ST_OK;
    if (it.cmd == CMD_CREATE || it.cmd == CMD_INSERT) begin
      if (it.cmd == CMD_CREATE) begin
        pq_count = 0;
        pq_made = 1'b1;
      end
      if (!pq_made) begin
        r.status = ST_NOT_CREATED;
      end else if (pq_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // place behind every entry of equal or higher priority
        pos = 0;
        while (pos < pq_count && pq_prio[pos] <= p) pos++;
        for (int i = pq_count; i > pos; i--) begin
          pq_data[i] = pq_data[i-1];
          pq_prio[i] = pq_prio[i-1];
        end
        pq_data[pos] = it.data;
        pq_prio[pos] = p;
        pq_count++;
      end
    end else if (it.cmd == CMD_DEQUEUE) begin
      if (!pq_made) begin
        r.status = ST_NOT_CREATED;
      end else if (pq_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.data = pq_data[0];
        r.prio = pq_prio[0];
        for (int i = 1; i < pq_count; i++) begin
          pq_data[i-1] = pq_data[i];
          pq_prio[i-1] = pq_prio[i];
        end
        pq_count--;
      end
    end
    r.count = pq_count[COUNT_W-1:0];
    return r;
  endfunction

  function automatic cmd_item_t make_cmd(logic [CMD_W-1:0] c, logic [DATA_W-1:0] d,
                                         logic [PRIO_W-1:0] p, logic w);
    cmd_item_t it;
    it.wait_idle = w;
    it.cmd = c;
    it.data = d;
    it.prio = p;
    return it;
  endfunction

  task automatic note_mismatch(input string what);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", what);
  endtask

  // Drive command beats in bursts with random gaps
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !in_taken) begin
      // hold the beat until it is taken
    end else if (gap_left > 0) begin
      s_tvalid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (cmd_backlog.size() == 0 ||
                 (cmd_backlog[0].wait_idle && pending_results.size() != 0)) begin
      s_tvalid <= 1'b0;
    end else begin
      s_tvalid <= 1'b1;
      s_tdata  <= {6'd0, cmd_backlog[0].prio, cmd_backlog[0].data};
      s_tuser  <= cmd_backlog[0].cmd;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // Stall the result side on a mode that changes now and then
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (sink_left == 0) begin
        sink_mode <= $urandom_range(0, 2);
        sink_left <= $urandom_range(20, 150);
      end else begin
        sink_left <= sink_left - 1;
      end
      case (sink_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        default: m_tready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // Check result beats, then predict for the command beat taken at this edge
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[16:0];
        got.data   = m_tdata[7:0];
        got.prio   = m_tdata[9:8];
        got.status = m_tdata[11:10];
        got.count  = m_tdata[16:12];
        if (pending_results.size() == 0) begin
          note_mismatch($sformatf("result beat with nothing expected, tdata %h", m_tdata));
        end else begin
          want = pending_results.pop_front();
          if (got.data != want.data)
            note_mismatch($sformatf("out_data exp %h got %h", want.data, got.data));
          if (got.prio != want.prio)
            note_mismatch($sformatf("out_priority exp %0d got %0d", want.prio, got.prio));
          if (got.status != want.status)
            note_mismatch($sformatf("status exp %0d got %0d", want.status, got.status));
          if (got.count != want.count)
            note_mismatch($sformatf("entry_count exp %0d got %0d", want.count, got.count));
        end
      end
      if (s_tvalid && s_tready) begin
        pending_results.push_back(serve_command(cmd_backlog.pop_front()));
      end
      in_taken <= s_tvalid && s_tready;
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Build the command list, release reset, then wait for the run to drain
  initial begin
    int made;
    int mode;
    int phase_len;
    int roll;
    logic [CMD_W-1:0] c;
    logic [PRIO_W-1:0] p;
    logic w;

    // directed: uncreated queue, every priority, equal priorities, empty, re-create
    cmd_backlog.push_back(make_cmd(CMD_DEQUEUE, 8'h00, 2'd1, 1'b0));
    cmd_backlog.push_back(make_cmd(CMD_INSERT,  8'hFF, 2'd3, 1'b0));
    cmd_backlog.push_back(make_cmd(CMD_NOP,     8'h00, 2'd0, 1'b0));
    cmd_backlog.push_back(make_cmd(CMD_CREATE,  8'h00, 2'd0, 1'b0));
    cmd_backlog.push_back(make_cmd(CMD_INSERT,  8'hFF, 2'd3, 1'b0));
    cmd_backlog.push_back(make_cmd(CMD_INSERT,  8'hAA, 2'd2, 1'b0));
    cmd_backlog.push_back(make_cmd(CMD_INSERT,  8'h55, 2'd1, 1'b0));
    cmd_backlog.push_back(make_cmd(CMD_INSERT,  8'h0F, 2'd0, 1'b0));
    cmd_backlog.push_back(make_cmd(CMD_INSERT,  8'hF0, 2'd3, 1'b0));
    cmd_backlog.push_back(make_cmd(CMD_NOP,     8'hFF, 2'd3, 1'b0));
    for (int i = 0; i < 7; i++)
      cmd_backlog.push_back(make_cmd(CMD_DEQUEUE, 8'h00, 2'd0, 1'b0));
    cmd_backlog.push_back(make_cmd(CMD_INSERT,  8'h33, 2'd2, 1'b0));
    cmd_backlog.push_back(make_cmd(CMD_CREATE,  8'hCC, 2'd3, 1'b0));
    cmd_backlog.push_back(make_cmd(CMD_DEQUEUE, 8'h00, 2'd0, 1'b0));

    // random phases that lean toward filling, draining or a mix
    made = 0;
    w = 1'b1;
    while (made < RANDOM_CMDS) begin
      mode = $urandom_range(0, 2);
      phase_len = $urandom_range(20, 80);
      for (int i = 0; i < phase_len; i++) begin
        roll = $urandom_range(0, 99);
        case (mode)
          0: c = (roll < 78) ? CMD_INSERT : (roll < 94) ? CMD_DEQUEUE :
                 (roll < 97) ? CMD_NOP : CMD_CREATE;
          1: c = (roll < 22) ? CMD_INSERT : (roll < 94) ? CMD_DEQUEUE :
                 (roll < 97) ? CMD_NOP : CMD_CREATE;
          default: c = (roll < 48) ? CMD_INSERT : (roll < 94) ? CMD_DEQUEUE :
                       (roll < 97) ? CMD_NOP : CMD_CREATE;
        endcase
        p = ($urandom_range(0, 9) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
        cmd_backlog.push_back(make_cmd(c, 8'($urandom_range(0, 255)), p, w));
        w = 1'b0;
        if (c != CMD_NOP) made++;
      end
      // let the block drain before some phases
      w = ($urandom_range(0, 2) == 0);
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (cmd_backlog.size() != 0) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
